>>> sv/odwsl_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the omni drive wheel speed limiter.
// No dependencies; every other file of the block imports this package.
package odwsl_pkg;

  // Field widths
  localparam int WHEEL_W = 11;                 // signed wheel speed, packet units
  localparam int MAG_W   = 11;                 // magnitude, 0..1024
  localparam int LIMIT_W = 10;                 // speed limit register
  localparam int QUO_W   = 10;                 // scaled magnitude, always below 1024
  localparam int NUM_W   = MAG_W + LIMIT_W;    // magnitude times limit

  // Divider: QUO_W quotient bits spread over DIV_STAGES stages
  localparam int DIV_STAGES = 5;
  localparam int DIV_BITS   = QUO_W / DIV_STAGES;

  // Queue depths and the width of their fill counts
  localparam int MID_DEPTH = 8;
  localparam int OUT_DEPTH = 16;
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  // Configuration space
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_SPEED_LIMIT = '0;
  localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RESET = 10'd673;

  // Omni-wheel matrix coefficients, scaled by 1e7
  localparam longint K_A   = 64'sd425995;
  localparam longint K_B   = 64'sd276645;
  localparam longint K_C   = 64'sd359169;
  localparam longint K_T   = 64'sd43175;
  localparam longint K_DEN = 64'sd10000000;

  // Operation codes
  typedef enum logic {
    OP_VELOCITY = 1'b0,
    OP_DIRECT   = 1'b1
  } op_e;

  typedef logic signed [WHEEL_W-1:0] wheel_t;
  typedef wheel_t [3:0]              wheel_vec_t;
  typedef logic [MAG_W-1:0]          mag_t;

  typedef struct packed {
    logic       limited;
    wheel_vec_t wheel;
  } result_t;

  // Queue status seen by the neighbors
  typedef struct packed {
    logic             empty;
    logic [CNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    mag_t rem;
    logic q;
  } div_step_t;

  function automatic mag_t mag_of(input wheel_t w);
    wheel_t neg;
    neg = -w;
    return w[WHEEL_W-1] ? mag_t'(neg) : mag_t'(w);
  endfunction

  // One restoring division step: shift in a numerator bit, subtract if it fits.
  function automatic div_step_t div_step(input mag_t rem, input logic nbit, input mag_t d);
    logic [MAG_W:0] t;
    logic [MAG_W:0] diff;
    div_step_t      r;
    t    = {rem, nbit};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      r.rem = diff[MAG_W-1:0];
      r.q   = 1'b1;
    end else begin
      r.rem = t[MAG_W-1:0];
      r.q   = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> sv/odwsl_fifo.sv
`timescale 1ns / 1ps
// Small register queue with a fill count, used between front and back and at the output.
// Depends on odwsl_pkg for the status struct.
module odwsl_fifo import odwsl_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rd_data_o,
  output q_stat_t          stat_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({wr_i, rd_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o    = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = CNT_W'(count_q);

endmodule

>>> sv/odwsl_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, runs velocity commands through the omni-wheel matrix.
// Two pipeline stages (products, sums), rounding on the way into the middle queue. Uses odwsl_pkg.
module odwsl_front import odwsl_pkg::*; #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  operation_i,
  input  logic signed [13:0]    vel_x_i,
  input  logic signed [13:0]    vel_y_i,
  input  logic signed [15:0]    ang_vel_i,
  input  wheel_vec_t            direct_i,
  input  q_stat_t               mid_stat_i,
  output logic                  full_o,
  output logic                  wr_o,
  output wheel_vec_t            wr_wheel_o
);

  // |sum| stays below 1024 << COEF_FRAC_BITS, so this holds every sum with room
  localparam int SumW = COEF_FRAC_BITS + 12;

  // Coefficients rounded to nearest at elaboration
  localparam longint CoefAInt = (K_A * (64'sd1 <<< COEF_FRAC_BITS) + K_DEN / 2) / K_DEN;
  localparam longint CoefBInt = (K_B * (64'sd1 <<< COEF_FRAC_BITS) + K_DEN / 2) / K_DEN;
  localparam longint CoefCInt = (K_C * (64'sd1 <<< COEF_FRAC_BITS) + K_DEN / 2) / K_DEN;
  localparam longint CoefTInt = (K_T * (64'sd1 <<< COEF_FRAC_BITS) + K_DEN / 2) / K_DEN;

  localparam logic signed [SumW-1:0] CoefA = SumW'(CoefAInt);
  localparam logic signed [SumW-1:0] CoefB = SumW'(CoefBInt);
  localparam logic signed [SumW-1:0] CoefC = SumW'(CoefCInt);
  localparam logic signed [SumW-1:0] CoefT = SumW'(CoefTInt);
  localparam logic [SumW-1:0]        RoundHalf = SumW'(64'd1 << (COEF_FRAC_BITS - 1));

  logic accept;

  // Stage 1: products
  logic                   v1_q;
  op_e                    op1_q;
  wheel_vec_t             dir1_q;
  logic signed [SumW-1:0] pax_q, pby_q, pcx_q, pcy_q, pt_q;

  // Stage 2: per-wheel sums
  logic                   v2_q;
  op_e                    op2_q;
  wheel_vec_t             dir2_q;
  logic signed [SumW-1:0] sum_q [4];

  logic [CNT_W:0] pending;

  // Hold off input when the middle queue cannot take everything already in flight
  assign pending = {1'b0, mid_stat_i.count} + (CNT_W + 1)'(v1_q) + (CNT_W + 1)'(v2_q);
  assign full_o  = (pending >= (CNT_W + 1)'(MID_DEPTH));
  assign accept  = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q  <= op_e'(operation_i);
    dir1_q <= direct_i;
    pax_q  <= SumW'(vel_x_i) * CoefA;
    pby_q  <= SumW'(vel_y_i) * CoefB;
    pcx_q  <= SumW'(vel_x_i) * CoefC;
    pcy_q  <= SumW'(vel_y_i) * CoefC;
    pt_q   <= SumW'(ang_vel_i) * CoefT;

    op2_q    <= op1_q;
    dir2_q   <= dir1_q;
    sum_q[0] <= pt_q - pax_q + pby_q;
    sum_q[1] <= pt_q - pcx_q - pcy_q;
    sum_q[2] <= pt_q + pcx_q - pcy_q;
    sum_q[3] <= pt_q + pax_q + pby_q;
  end

  // Round half away from zero on the magnitude, then restore the sign
  always_comb begin
    logic [SumW-1:0] mag;
    logic [SumW-1:0] rnd;
    wheel_t          r;
    for (int i = 0; i < 4; i++) begin
      mag = sum_q[i][SumW-1] ? SumW'(-sum_q[i]) : SumW'(sum_q[i]);
      rnd = (mag + RoundHalf) >> COEF_FRAC_BITS;
      r   = WHEEL_W'(rnd);
      if (op2_q == OP_DIRECT) begin
        wr_wheel_o[i] = dir2_q[i];
      end else begin
        wr_wheel_o[i] = sum_q[i][SumW-1] ? -r : r;
      end
    end
  end

  assign wr_o = v2_q;

endmodule

>>> sv/odwsl_back.sv
`timescale 1ns / 1ps
// Back end: finds the largest wheel magnitude and, when it exceeds the limit, scales all four to the limit.
// Compare stage, multiply stage, then a five-stage restoring divider. Uses odwsl_pkg.
module odwsl_back import odwsl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [LIMIT_W-1:0] limit_i,
  input  q_stat_t            mid_stat_i,
  input  wheel_vec_t         mid_wheel_i,
  output logic               mid_rd_o,
  input  q_stat_t            out_stat_i,
  output logic               out_wr_o,
  output result_t            out_data_o
);

  localparam int LoW = NUM_W - MAG_W;   // numerator bits below the initial remainder

  // Stage A: magnitudes and maximum
  logic   va_q;
  wheel_vec_t wa_q;
  mag_t   ma_q [4];
  mag_t   maxa_q;
  logic   lima_q;

  mag_t   mag_c [4];
  mag_t   max01, max23, max_c;

  // Stage 0 (multiply result) through DIV_STAGES (quotient done)
  logic [DIV_STAGES:0] vd_q;
  wheel_vec_t          wd_q   [DIV_STAGES+1];
  mag_t                maxd_q [DIV_STAGES+1];
  logic                limd_q [DIV_STAGES+1];
  mag_t                rem_q  [DIV_STAGES+1][4];
  logic [LoW-1:0]      lo_q   [DIV_STAGES+1][4];
  logic [QUO_W-1:0]    quo_q  [DIV_STAGES+1][4];

  mag_t             rem_d [DIV_STAGES+1][4];
  logic [LoW-1:0]   lo_d  [DIV_STAGES+1][4];
  logic [QUO_W-1:0] quo_d [DIV_STAGES+1][4];

  logic [CNT_W:0] pending;

  // Credit check: take from the middle queue only when the output queue has room
  // for everything already in the pipeline
  assign pending  = {1'b0, out_stat_i.count} + (CNT_W + 1)'($countones({va_q, vd_q}));
  assign mid_rd_o = !mid_stat_i.empty && (pending < (CNT_W + 1)'(OUT_DEPTH));

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_c[i] = mag_of(mid_wheel_i[i]);
    end
    max01 = (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
    max23 = (mag_c[2] > mag_c[3]) ? mag_c[2] : mag_c[3];
    max_c = (max01 > max23) ? max01 : max23;
  end

  // Multiply stage feeds divider stage 0; later stages each retire DIV_BITS quotient bits
  always_comb begin
    logic [NUM_W-1:0] num;
    div_step_t        st;
    for (int i = 0; i < 4; i++) begin
      num           = NUM_W'(ma_q[i]) * NUM_W'(limit_i);
      rem_d[0][i]   = num[NUM_W-1:LoW];
      lo_d[0][i]    = num[LoW-1:0];
      quo_d[0][i]   = '0;
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      for (int i = 0; i < 4; i++) begin
        rem_d[k][i] = rem_q[k-1][i];
        lo_d[k][i]  = lo_q[k-1][i];
        quo_d[k][i] = quo_q[k-1][i];
        for (int j = 0; j < DIV_BITS; j++) begin
          st          = div_step(rem_d[k][i], lo_d[k][i][LoW-1], maxd_q[k-1]);
          rem_d[k][i] = st.rem;
          lo_d[k][i]  = {lo_d[k][i][LoW-2:0], 1'b0};
          quo_d[k][i] = {quo_d[k][i][QUO_W-2:0], st.q};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vd_q <= '0;
    end else begin
      va_q <= mid_rd_o;
      vd_q <= {vd_q[DIV_STAGES-1:0], va_q};
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q   <= mid_wheel_i;
    maxa_q <= max_c;
    lima_q <= (max_c > MAG_W'(limit_i));
    for (int i = 0; i < 4; i++) begin
      ma_q[i] <= mag_c[i];
    end

    wd_q[0]   <= wa_q;
    maxd_q[0] <= maxa_q;
    limd_q[0] <= lima_q;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      wd_q[k]   <= wd_q[k-1];
      maxd_q[k] <= maxd_q[k-1];
      limd_q[k] <= limd_q[k-1];
    end
    for (int k = 0; k <= DIV_STAGES; k++) begin
      for (int i = 0; i < 4; i++) begin
        rem_q[k][i] <= rem_d[k][i];
        lo_q[k][i]  <= lo_d[k][i];
        quo_q[k][i] <= quo_d[k][i];
      end
    end
  end

  // Scaled magnitude takes the sign of the original speed
  always_comb begin
    wheel_t q;
    for (int i = 0; i < 4; i++) begin
      q = WHEEL_W'(quo_q[DIV_STAGES][i]);
      if (limd_q[DIV_STAGES]) begin
        out_data_o.wheel[i] = wd_q[DIV_STAGES][i][WHEEL_W-1] ? -q : q;
      end else begin
        out_data_o.wheel[i] = wd_q[DIV_STAGES][i];
      end
    end
    out_data_o.limited = limd_q[DIV_STAGES];
  end

  assign out_wr_o = vd_q[DIV_STAGES];

endmodule

>>> sv/omni_drive_wheel_speed_limiter.sv
`timescale 1ns / 1ps
// Omni drive wheel speed limiter, top level: APB register, front end, queues, back end.
// Depends on odwsl_pkg, odwsl_fifo, odwsl_front and odwsl_back.
//
// Usage
//   Input queue: drive the item on the payload ports and raise push; the item is
//   taken at a clock edge where push is high and full is low. operation = 0 is a
//   body velocity command (vel_x, vel_y, ang_vel), operation = 1 gives four direct
//   wheel speeds. Unused fields are ignored.
//   Result queue: while empty is low the oldest result sits on wheel_out_* and
//   was_limited; raise pop to take it. One result per item, in order.
//   APB: one register, speed_limit, at byte address 0 (10 bits, reset 673). Write
//   only while the block is idle. pready is tied high.
// Pipeline
//   An item that is taken passes through two matrix stages, the middle queue,
//   the magnitude/max compare, the magnitude-times-limit multiply, five divider
//   stages (two quotient bits each) and the output queue write, and then sits on
//   the result ports. Throughput is one item per cycle while full stays low.
// Stalls and reset
//   If pop stays low the output queue fills, the back end stops pulling from the
//   middle queue, and full rises once the middle queue is committed. No item is
//   dropped. Reset empties both queues and restores speed_limit to 673.
module omni_drive_wheel_speed_limiter import odwsl_pkg::*; #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  // Input queue
  input  logic                push,
  output logic                full,
  input  logic                operation_i,
  input  logic signed [13:0]  vel_x_i,
  input  logic signed [13:0]  vel_y_i,
  input  logic signed [15:0]  ang_vel_i,
  input  logic signed [10:0]  direct_speed_1_i,
  input  logic signed [10:0]  direct_speed_2_i,
  input  logic signed [10:0]  direct_speed_3_i,
  input  logic signed [10:0]  direct_speed_4_i,
  // Result queue
  output logic                empty,
  input  logic                pop,
  output logic signed [10:0]  wheel_out_1_o,
  output logic signed [10:0]  wheel_out_2_o,
  output logic signed [10:0]  wheel_out_3_o,
  output logic signed [10:0]  wheel_out_4_o,
  output logic                was_limited_o
);

  localparam int MidW = $bits(wheel_vec_t);
  localparam int OutW = $bits(result_t);

  logic [LIMIT_W-1:0] speed_limit_q, speed_limit_d;
  logic               reg_hit;

  wheel_vec_t direct;
  q_stat_t    mid_stat, out_stat;
  logic       mid_wr, mid_rd, out_wr, out_rd;
  wheel_vec_t mid_wr_wheel;
  logic [MidW-1:0] mid_rd_data;
  result_t    out_wr_data;
  logic [OutW-1:0] out_rd_data;
  result_t    head;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_SPEED_LIMIT);

  always_comb begin
    speed_limit_d = speed_limit_q;
    if (psel && penable && pwrite && pready && reg_hit) begin
      speed_limit_d = pwdata[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_limit_q <= SPEED_LIMIT_RESET;
    end else begin
      speed_limit_q <= speed_limit_d;
    end
  end

  assign prdata = reg_hit ? DATA_W'(speed_limit_q) : '0;

  // ---------------------------------------------------------------------------
  // Front end: matrix and rounding
  // ---------------------------------------------------------------------------
  assign direct[0] = direct_speed_1_i;
  assign direct[1] = direct_speed_2_i;
  assign direct[2] = direct_speed_3_i;
  assign direct[3] = direct_speed_4_i;

  odwsl_front #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .operation_i (operation_i),
    .vel_x_i     (vel_x_i),
    .vel_y_i     (vel_y_i),
    .ang_vel_i   (ang_vel_i),
    .direct_i    (direct),
    .mid_stat_i  (mid_stat),
    .full_o      (full),
    .wr_o        (mid_wr),
    .wr_wheel_o  (mid_wr_wheel)
  );

  // Middle queue decouples the matrix from the limiter
  odwsl_fifo #(
    .WIDTH (MidW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (mid_wr),
    .wr_data_i (mid_wr_wheel),
    .rd_i      (mid_rd),
    .rd_data_o (mid_rd_data),
    .stat_o    (mid_stat)
  );

  // ---------------------------------------------------------------------------
  // Back end: max, multiply, divide
  // ---------------------------------------------------------------------------
  odwsl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (speed_limit_q),
    .mid_stat_i  (mid_stat),
    .mid_wheel_i (wheel_vec_t'(mid_rd_data)),
    .mid_rd_o    (mid_rd),
    .out_stat_i  (out_stat),
    .out_wr_o    (out_wr),
    .out_data_o  (out_wr_data)
  );

  assign out_rd = pop && !out_stat.empty;

  odwsl_fifo #(
    .WIDTH (OutW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (out_wr),
    .wr_data_i (out_wr_data),
    .rd_i      (out_rd),
    .rd_data_o (out_rd_data),
    .stat_o    (out_stat)
  );

  assign head          = result_t'(out_rd_data);
  assign empty         = out_stat.empty;
  assign wheel_out_1_o = head.wheel[0];
  assign wheel_out_2_o = head.wheel[1];
  assign wheel_out_3_o = head.wheel[2];
  assign wheel_out_4_o = head.wheel[3];
  assign was_limited_o = head.limited;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Credit logic must never write a full queue
  a_mid_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_wr |-> (mid_stat.count < CNT_W'(MID_DEPTH)))
    else $error("middle queue written while full");

  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_wr |-> (out_stat.count < CNT_W'(OUT_DEPTH)))
    else $error("output queue written while full");

  // The first wheel of a scaled result stays within the limit
  a_limited_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && was_limited_o) |->
      (wheel_out_1_o <= $signed({1'b0, speed_limit_q}) &&
       wheel_out_1_o >= -$signed({1'b0, speed_limit_q})))
    else $error("limited wheel speed exceeds the limit");

  // The limiter only reads a nonempty middle queue
  a_mid_rd_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_rd |-> !mid_stat.empty)
    else $error("middle queue read while empty");

endmodule
